// ----- src/lome_pkg.sv -----
package lome_pkg;

	localparam int INDEX_BITS = 20;
	localparam int BEATS_MAX = 4;
	localparam int BEAT_IDX_BITS = $clog2(BEATS_MAX);
	localparam int DELTA_EXT_BITS = INDEX_BITS + 1 > 33 ? INDEX_BITS + 1 : 33;

	localparam logic [7:0] THRESHOLD_RESET = 8'd16;
	localparam logic [DELTA_EXT_BITS-1:0] SHORT_DELTA_MAX = DELTA_EXT_BITS'(127);
	localparam logic [DELTA_EXT_BITS-1:0] LONG_DELTA_MAX = DELTA_EXT_BITS'(32767);
	localparam logic [7:0] LONG_DELTA_MARK = 8'h80;

	localparam logic STREAM_MERGED = 1'b0;
	localparam logic STREAM_RECORD = 1'b1;

	typedef logic [INDEX_BITS-1:0] index_t;

	typedef struct packed {
		logic stream_select;
		logic [7:0] byte_value;
		logic delta_overflow;
	} beat_t;

	typedef struct packed {
		beat_t [BEATS_MAX-1:0] beats;
		logic [BEAT_IDX_BITS-1:0] last_beat;
	} record_t;

	function automatic logic [3:0] bit_count8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

endpackage

// ----- src/lome_classify.sv -----
module lome_classify
	import lome_pkg::*;
(
	input  logic [7:0] occupancy_first,
	input  logic [7:0] occupancy_second,
	input  logic [7:0] threshold,
	input  index_t     leaf_index,
	input  index_t     last_exception_index,
	output logic       similar,
	output record_t    rec
);

	logic [3:0] xor_count;
	logic [3:0] count_first;
	logic [3:0] count_second;
	logic [3:0] min_count;
	logic [3:0] min_plus_one;
	logic [11:0] lhs;
	logic [11:0] rhs;
	index_t delta;
	logic [DELTA_EXT_BITS-1:0] delta_ext;
	logic is_short;
	logic ovf;

	always_comb begin
		xor_count = bit_count8(occupancy_first ^ occupancy_second);
		count_first = bit_count8(occupancy_first);
		count_second = bit_count8(occupancy_second);
		min_count = (count_first < count_second) ? count_first : count_second;
		min_plus_one = min_count + 4'd1;
		lhs = 12'({xor_count, 4'b0000});
		rhs = 12'(threshold) * 12'(min_plus_one);
		similar = lhs <= rhs;

		delta = leaf_index - last_exception_index;
		delta_ext = DELTA_EXT_BITS'(delta);
		is_short = delta_ext <= SHORT_DELTA_MAX;
		ovf = delta_ext > LONG_DELTA_MAX;
	end

	always_comb begin
		rec = '0;
		rec.beats[0].stream_select = STREAM_MERGED;
		rec.beats[0].delta_overflow = 1'b0;
		if (similar) begin
			rec.beats[0].byte_value = occupancy_first | occupancy_second;
			rec.last_beat = BEAT_IDX_BITS'(0);
		end else begin
			rec.beats[0].byte_value = occupancy_first;
			if (is_short) begin
				rec.beats[1] = '{STREAM_RECORD, delta_ext[7:0], 1'b0};
				rec.beats[2] = '{STREAM_RECORD, occupancy_second, 1'b0};
				rec.last_beat = BEAT_IDX_BITS'(2);
			end else begin
				rec.beats[1] = '{STREAM_RECORD, LONG_DELTA_MARK | {1'b0, delta_ext[14:8]}, ovf};
				rec.beats[2] = '{STREAM_RECORD, delta_ext[7:0], ovf};
				rec.beats[3] = '{STREAM_RECORD, occupancy_second, ovf};
				rec.last_beat = BEAT_IDX_BITS'(3);
			end
		end
	end

endmodule

// ----- src/lome_serializer.sv -----
module lome_serializer
	import lome_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  record_t    rec,
	output logic       free,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,
	output logic [1:0] m_axis_tuser,
	output logic       m_axis_tlast
);

	record_t rec_q;
	logic [BEAT_IDX_BITS-1:0] idx_q;
	logic valid_q;
	logic at_last;
	logic taken;
	beat_t cur;

	assign cur = rec_q.beats[idx_q];
	assign at_last = idx_q == rec_q.last_beat;
	assign taken = valid_q && m_axis_tready;
	assign free = !valid_q || (taken && at_last);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = cur.byte_value;
	assign m_axis_tuser = {cur.delta_overflow, cur.stream_select};
	assign m_axis_tlast = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (free) begin
			valid_q <= load;
			idx_q <= '0;
		end else if (taken) begin
			idx_q <= idx_q + BEAT_IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			rec_q <= rec;
		end
	end

endmodule

// ----- src/leaf_occupancy_merge_encoder.sv -----
// Takes one pair of leaf occupancy bytes per input beat and emits the merged
// byte (the OR of the pair if similar, else the first byte), followed by an
// exception record when the pair is not similar, one byte per output beat. A
// similar pair yields one byte, an exception with a short delta three and one
// with a long delta four. Input beats are taken in every cycle in which the
// input register is empty or the result register frees. The first byte of an
// item is presented once its beat has been loaded from the input register into
// the serializer. The threshold must only be written while the block is idle.
module leaf_occupancy_merge_encoder
	import lome_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // occupancy_first, occupancy_second
	input  logic        s_axis_tuser,  // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // byte_value
	output logic [1:0]  m_axis_tuser,  // stream_select, delta_overflow
	output logic        m_axis_tlast   // last_of_item
);

	logic [7:0] threshold_q;
	index_t leaf_q;
	index_t last_exc_q;

	logic valid_s1;
	logic [7:0] first_s1;
	logic [7:0] second_s1;
	logic start_s1;

	index_t leaf_eff;
	index_t last_eff;
	logic similar;
	record_t rec;
	logic free;
	logic load;

	assign cfg_ready = 1'b1;
	assign load = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			first_s1 <= s_axis_tdata[7:0];
			second_s1 <= s_axis_tdata[15:8];
			start_s1 <= s_axis_tuser;
		end
	end

	assign leaf_eff = start_s1 ? '0 : leaf_q;
	assign last_eff = start_s1 ? '0 : last_exc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q <= '0;
			last_exc_q <= '0;
		end else if (load) begin
			leaf_q <= leaf_eff + INDEX_BITS'(1);
			last_exc_q <= similar ? last_eff : leaf_eff;
		end
	end

	lome_classify u_classify (
		.occupancy_first      (first_s1),
		.occupancy_second     (second_s1),
		.threshold            (threshold_q),
		.leaf_index           (leaf_eff),
		.last_exception_index (last_eff),
		.similar              (similar),
		.rec                  (rec)
	);

	lome_serializer u_serializer (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.rec           (rec),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- src/lome_checker.sv -----
module lome_checker
	import lome_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled output beat keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
				&& $stable(m_axis_tlast)))
		else $error("output beat changed while stalled");

	// Once an item has begun, its remaining beats follow without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("gap inside the beats of one item");

	// A merged byte that is not the last of its item is followed by a record byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast
			&& m_axis_tuser[0] == STREAM_MERGED) |=> (m_axis_tuser[0] == STREAM_RECORD))
		else $error("merged byte not followed by its record");

	// After the last beat of an item, the next item opens with its merged byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
			!(m_axis_tvalid && m_axis_tuser[0] == STREAM_RECORD))
		else $error("record byte without a preceding merged byte");

	// The merged byte never carries the overflow flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] == STREAM_MERGED) |-> !m_axis_tuser[1])
		else $error("overflow flag on a merged byte");

endmodule

bind leaf_occupancy_merge_encoder lome_checker u_checker (.*);
